// ===== src/cfe_pkg.sv =====
// Shared types, constants and helper functions for the cuckoo filter engine.
// No dependencies; the files that use it refer to this package by scoped names.
package cfe_pkg;

  localparam int BUCKET_COUNT     = 1024;
  localparam int SLOTS_PER_BUCKET = 4;
  localparam int MAX_KICKS        = 512;

  localparam int BKT_W    = $clog2(BUCKET_COUNT);
  localparam int SLOT_W   = $clog2(SLOTS_PER_BUCKET);
  localparam int FP_W     = 16;
  localparam int BUCKET_W = FP_W * SLOTS_PER_BUCKET;
  localparam int KICK_W   = $clog2(MAX_KICKS + 1);
  localparam int CNT_W    = 13;
  localparam int HASH_W   = 64;

  localparam logic [CNT_W-1:0] COUNT_MAX  = 13'd8191;
  localparam logic [15:0]      LFSR_TAPS  = 16'hB400;
  localparam logic [15:0]      SEED_RESET = 16'd44257;

  localparam logic [63:0] XP1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] XP2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] XP3 = 64'h165667B19E3779F9;
  localparam logic [63:0] XP5 = 64'h27D4EB2F165667C5;
  localparam logic [63:0] H0  = 64'd1 + XP5 + 64'd2;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Result codes: NO is absent or duplicate, YES is hit, stored or cleared
  localparam logic [1:0] ST_NO   = 2'd0;
  localparam logic [1:0] ST_YES  = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  typedef struct packed {
    logic            start;
    logic [FP_W-1:0] fp;
  } hash_req_t;

  typedef struct packed {
    logic             done;
    logic [BKT_W-1:0] top;
  } hash_rsp_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] idx;
  } slot_hit_t;

  // First slot of a bucket holding the given value
  function automatic slot_hit_t find_slot(input logic [BUCKET_W-1:0] b,
                                          input logic [FP_W-1:0] v);
    slot_hit_t r;
    r.hit = 1'b0;
    r.idx = '0;
    for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--) begin
      if (b[i*FP_W +: FP_W] == v) begin
        r.hit = 1'b1;
        r.idx = SLOT_W'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [BUCKET_W-1:0] set_slot(input logic [BUCKET_W-1:0] b,
                                                   input logic [SLOT_W-1:0] idx,
                                                   input logic [FP_W-1:0] v);
    logic [BUCKET_W-1:0] r;
    r = b;
    r[idx*FP_W +: FP_W] = v;
    return r;
  endfunction

endpackage

// ===== src/cfe_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cfe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/cfe_hash.sv =====
// Fingerprint hash unit: 64-bit avalanche hash over two fingerprint bytes,
// built on one shared 32x32 multiplier. Depends on cfe_pkg.
module cfe_hash (
  input  logic               clk,
  input  logic               rst,
  input  cfe_pkg::hash_req_t req,
  output cfe_pkg::hash_rsp_t rsp
);

  typedef enum logic [2:0] {
    PH_LOAD,
    PH_LL,
    PH_LH,
    PH_HL,
    PH_POST
  } ph_t;

  localparam logic [2:0] LAST_MUL = 3'd5;

  ph_t                       ph;
  logic                      busy;
  logic                      done;
  logic [2:0]                k;
  logic [cfe_pkg::FP_W-1:0]  fp_r;
  logic [63:0]               h;
  logic [63:0]               a_reg;
  logic [63:0]               prod;
  logic [63:0]               acc;
  logic [63:0]               b_const;
  logic [63:0]               a_next;
  logic [63:0]               r_full;
  logic [63:0]               h_next;
  logic [31:0]               mul_x;
  logic [31:0]               mul_y;
  logic [63:0]               mul_out;

  always_comb begin
    case (k)
      3'd0, 3'd2: b_const = cfe_pkg::XP5;
      3'd1, 3'd3: b_const = cfe_pkg::XP1;
      3'd4:       b_const = cfe_pkg::XP2;
      default:    b_const = cfe_pkg::XP3;
    endcase
  end

  // Operand going into each multiplication
  always_comb begin
    case (k)
      3'd0:    a_next = {56'd0, fp_r[7:0]};
      3'd2:    a_next = {56'd0, fp_r[15:8]};
      3'd1,
      3'd3:    a_next = {h[52:0], h[63:53]};
      3'd4:    a_next = h ^ (h >> 33);
      default: a_next = h ^ (h >> 29);
    endcase
  end

  assign r_full = {acc[63:32] + prod[31:0], acc[31:0]};

  always_comb begin
    case (k)
      3'd0:    h_next = cfe_pkg::H0 ^ r_full;
      3'd2:    h_next = h ^ r_full;
      3'd5:    h_next = r_full ^ (r_full >> 32);
      default: h_next = r_full;
    endcase
  end

  // Partial products of the low 64 bits: lo*lo, lo*hi, hi*lo
  assign mul_x   = (ph == PH_HL) ? a_reg[63:32] : a_reg[31:0];
  assign mul_y   = (ph == PH_LH) ? b_const[63:32] : b_const[31:0];
  assign mul_out = 64'(mul_x) * 64'(mul_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ph   <= PH_LOAD;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (req.start) begin
          busy <= 1'b1;
          fp_r <= req.fp;
          k    <= '0;
          ph   <= PH_LOAD;
        end
      end else begin
        case (ph)
          PH_LOAD: begin
            a_reg <= a_next;
            ph    <= PH_LL;
          end
          PH_LL: begin
            prod <= mul_out;
            ph   <= PH_LH;
          end
          PH_LH: begin
            acc  <= prod;
            prod <= mul_out;
            ph   <= PH_HL;
          end
          PH_HL: begin
            acc[63:32] <= acc[63:32] + prod[31:0];
            prod       <= mul_out;
            ph         <= PH_POST;
          end
          PH_POST: begin
            h  <= h_next;
            ph <= PH_LOAD;
            if (k == LAST_MUL) begin
              busy <= 1'b0;
              done <= 1'b1;
            end else begin
              k <= k + 3'd1;
            end
          end
          default: ph <= PH_LOAD;
        endcase
      end
    end
  end

  assign rsp.done = done;
  assign rsp.top  = h[63 -: cfe_pkg::BKT_W];

endmodule

// ===== src/cuckoo_filter_engine_unit.sv =====
// Cuckoo filter engine, top level: sequencer, bucket RAM, hash unit, LFSR.
// Depends on cfe_pkg, cfe_ram and cfe_hash.
// Query, delete and a direct insert are dominated by the fingerprint hash (six 64-bit
// multiplies on one 32x32 multiplier); each eviction hashes its victim again, up to
// 512 evictions. A zero fingerprint skips the hash and the bucket RAM. Clear and
// reset sweep the bucket RAM one bucket a cycle.
// Throughput: one word at a time; s_axis_tready is low while a word is at work.
// Reset: synchronous; empties all buckets, zeroes the count, loads the seed.
module cuckoo_filter_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // [63:0] key_hash, [79:64] fingerprint
  input  logic [1:0]  s_axis_tuser,  // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [1:0] status, [14:2] item_count, [15] zero
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata      // random_seed
);

  localparam int BKT_W  = cfe_pkg::BKT_W;
  localparam int FP_W   = cfe_pkg::FP_W;
  localparam int BW     = cfe_pkg::BUCKET_W;
  localparam int SLOT_W = cfe_pkg::SLOT_W;
  localparam int CNT_W  = cfe_pkg::CNT_W;
  localparam int KICK_W = cfe_pkg::KICK_W;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_HASH,
    S_RDP,
    S_RDA,
    S_GOTA,
    S_EVAL,
    S_KICK,
    S_KHASH,
    S_KRD,
    S_KWAIT,
    S_KEVAL,
    S_OUT
  } state_t;

  state_t             state;
  cfe_pkg::op_t       op_r;
  logic [FP_W-1:0]    cur;
  logic [BKT_W-1:0]   p;
  logic [BKT_W-1:0]   a;
  logic [BKT_W-1:0]   ri;
  logic [BW-1:0]      bp;
  logic [BW-1:0]      ba;
  logic [KICK_W-1:0]  kcnt;
  logic [BKT_W-1:0]   clr_addr;
  logic               clr_rsp;
  logic [CNT_W-1:0]   count;
  logic [15:0]        lfsr;
  logic [1:0]         res_status;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [CNT_W-1:0]   out_count;

  logic               accept;
  cfe_pkg::op_t       in_op;
  logic [FP_W-1:0]    in_fp;
  logic [15:0]        draw;
  logic [SLOT_W-1:0]  slot_v;
  logic [FP_W-1:0]    victim;
  cfe_pkg::slot_hit_t hp, ha, ep, ea;

  logic               we;
  logic [BKT_W-1:0]   waddr;
  logic [BW-1:0]      wdata;
  logic [BKT_W-1:0]   raddr;
  logic [BW-1:0]      rdata;

  cfe_pkg::hash_req_t hreq;
  cfe_pkg::hash_rsp_t hrsp;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_op         = cfe_pkg::op_t'(s_axis_tuser);
  assign in_fp         = s_axis_tdata[79:64];

  // One LFSR step per draw; the draw is the new state
  assign draw   = (lfsr >> 1) ^ (lfsr[0] ? cfe_pkg::LFSR_TAPS : 16'd0);
  assign slot_v = draw[SLOT_W-1:0];
  assign victim = bp[slot_v*FP_W +: FP_W];

  // Slot lookups on the held buckets; the kick path reuses bp
  assign hp = cfe_pkg::find_slot(bp, cur);
  assign ha = cfe_pkg::find_slot(ba, cur);
  assign ep = cfe_pkg::find_slot(bp, '0);
  assign ea = cfe_pkg::find_slot(ba, '0);

  // Start the hash on a new non-clear word with a nonzero fingerprint, or on the victim of a kick
  assign hreq.start = (accept && in_op != cfe_pkg::OP_CLEAR && in_fp != '0) ||
                      (state == S_KICK);
  assign hreq.fp    = (state == S_KICK) ? victim : in_fp;

  cfe_hash u_hash (
    .clk (clk),
    .rst (rst),
    .req (hreq),
    .rsp (hrsp)
  );

  cfe_ram #(
    .WIDTH (BW),
    .DEPTH (cfe_pkg::BUCKET_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    case (state)
      S_RDA:   raddr = a;
      S_KRD:   raddr = ri;
      default: raddr = p;
    endcase
  end

  // Bucket write-back for clear, delete, place and evict
  always_comb begin
    we    = 1'b0;
    waddr = p;
    wdata = bp;
    case (state)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      S_EVAL: begin
        if (op_r == cfe_pkg::OP_DELETE) begin
          if (hp.hit) begin
            we    = 1'b1;
            wdata = cfe_pkg::set_slot(bp, hp.idx, '0);
          end else if (ha.hit) begin
            we    = 1'b1;
            waddr = a;
            wdata = cfe_pkg::set_slot(ba, ha.idx, '0);
          end
        end else if (op_r == cfe_pkg::OP_INSERT && !hp.hit && !ha.hit) begin
          if (ep.hit) begin
            we    = 1'b1;
            wdata = cfe_pkg::set_slot(bp, ep.idx, cur);
          end else if (ea.hit) begin
            we    = 1'b1;
            waddr = a;
            wdata = cfe_pkg::set_slot(ba, ea.idx, cur);
          end
        end
      end
      S_KICK: begin
        we    = 1'b1;
        waddr = ri;
        wdata = cfe_pkg::set_slot(bp, slot_v, cur);
      end
      S_KEVAL: begin
        if (!hp.hit && ep.hit) begin
          we    = 1'b1;
          waddr = ri;
          wdata = cfe_pkg::set_slot(bp, ep.idx, cur);
        end
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      clr_rsp   <= 1'b0;
      count     <= '0;
      lfsr      <= cfe_pkg::SEED_RESET;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + BKT_W'(1);
          if (clr_addr == BKT_W'(cfe_pkg::BUCKET_COUNT - 1)) begin
            if (clr_rsp) begin
              res_status <= cfe_pkg::ST_YES;
              state      <= S_OUT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_r <= in_op;
            cur  <= in_fp;
            p    <= s_axis_tdata[BKT_W-1:0];
            if (in_op == cfe_pkg::OP_CLEAR) begin
              count    <= '0;
              clr_addr <= '0;
              clr_rsp  <= 1'b1;
              state    <= S_CLR;
            end else if (in_fp == '0) begin
              // Zero fingerprint: answer at once, touch nothing
              res_status <= (in_op == cfe_pkg::OP_INSERT) ? cfe_pkg::ST_FAIL
                                                          : cfe_pkg::ST_NO;
              state      <= S_OUT;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hrsp.done) begin
            a     <= p ^ hrsp.top;
            state <= S_RDP;
          end
        end
        S_RDP: state <= S_RDA;
        S_RDA: begin
          bp    <= rdata;
          state <= S_GOTA;
        end
        S_GOTA: begin
          ba    <= rdata;
          state <= S_EVAL;
        end
        S_EVAL: begin
          state <= S_OUT;
          case (op_r)
            cfe_pkg::OP_QUERY: begin
              res_status <= (hp.hit || ha.hit) ? cfe_pkg::ST_YES : cfe_pkg::ST_NO;
            end
            cfe_pkg::OP_DELETE: begin
              if (hp.hit || ha.hit) begin
                res_status <= cfe_pkg::ST_YES;
                if (count != '0) begin
                  count <= count - CNT_W'(1);
                end
              end else begin
                res_status <= cfe_pkg::ST_NO;
              end
            end
            default: begin
              if (hp.hit || ha.hit) begin
                res_status <= cfe_pkg::ST_NO;
              end else if (ep.hit || ea.hit) begin
                res_status <= cfe_pkg::ST_YES;
                if (count != cfe_pkg::COUNT_MAX) begin
                  count <= count + CNT_W'(1);
                end
              end else begin
                // Both buckets full: pick the first victim bucket
                lfsr  <= draw;
                ri    <= draw[0] ? p : a;
                bp    <= draw[0] ? bp : ba;
                kcnt  <= '0;
                state <= S_KICK;
              end
            end
          endcase
        end
        S_KICK: begin
          // Swap the carried fingerprint into the victim slot
          lfsr  <= draw;
          cur   <= victim;
          state <= S_KHASH;
        end
        S_KHASH: begin
          if (hrsp.done) begin
            ri    <= ri ^ hrsp.top;
            state <= S_KRD;
          end
        end
        S_KRD: state <= S_KWAIT;
        S_KWAIT: begin
          bp    <= rdata;
          state <= S_KEVAL;
        end
        S_KEVAL: begin
          if (hp.hit) begin
            res_status <= cfe_pkg::ST_NO;
            state      <= S_OUT;
          end else if (ep.hit) begin
            res_status <= cfe_pkg::ST_YES;
            if (count != cfe_pkg::COUNT_MAX) begin
              count <= count + CNT_W'(1);
            end
            state <= S_OUT;
          end else if (kcnt == KICK_W'(cfe_pkg::MAX_KICKS - 1)) begin
            res_status <= cfe_pkg::ST_FAIL;
            state      <= S_OUT;
          end else begin
            kcnt  <= kcnt + KICK_W'(1);
            state <= S_KICK;
          end
        end
        S_OUT: begin
          // Hold here until the output register is free
          if (!out_valid || m_axis_tready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_count  <= count;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we) begin
        lfsr <= (cfg_wdata == 16'd0) ? 16'd1 : cfg_wdata;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_count, out_status};

endmodule

// ===== src/cfe_checker.sv =====
// Port-level checks for the cuckoo filter engine, bound to the top level.
// Depends on cuckoo_filter_engine_unit.
module cfe_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("input ready during the reset sweep");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("undefined status code");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared the cycle after accept");

endmodule

bind cuckoo_filter_engine_unit cfe_checker u_cfe_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/tb.sv =====
// Self-checking bench for cuckoo_filter_engine_unit: directed table, then random
// query/insert/delete/clear traffic checked against an in-bench filter model.
// Depends on cfe_pkg and the RTL under src.
module tb;

  localparam int NB = 1024;
  localparam int NS = 4;
  localparam int WATCHDOG_LIMIT = 200000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;   // [63:0] key_hash, [79:64] fingerprint
  logic [1:0]  s_axis_tuser;   // [1:0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [1:0] status, [14:2] item_count, [15] zero
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  cuckoo_filter_engine_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] count;
  } filter_result_t;

  typedef struct {
    cfe_pkg::op_t op;
    logic [63:0]  key;
    logic [15:0]  fp;
    logic         has_golden;
    logic [1:0]   golden_status;
    logic [12:0]  golden_count;
  } stim_row_t;

  // Bench copy of the filter state
  logic [15:0] shadow_slots [NB][NS];
  int unsigned shadow_count;
  logic [15:0] shadow_lfsr;

  filter_result_t pending_results[$];
  int mismatch_count;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rot11(input logic [63:0] v);
    return {v[52:0], v[63:53]};
  endfunction

  function automatic logic [9:0] fp_top_bits(input logic [15:0] fp);
    logic [63:0] h;
    h = 64'd1 + cfe_pkg::XP5 + 64'd2;
    h = h ^ ({56'd0, fp[7:0]} * cfe_pkg::XP5);
    h = rot11(h) * cfe_pkg::XP1;
    h = h ^ ({56'd0, fp[15:8]} * cfe_pkg::XP5);
    h = rot11(h) * cfe_pkg::XP1;
    h = h ^ (h >> 33);
    h = h * cfe_pkg::XP2;
    h = h ^ (h >> 29);
    h = h * cfe_pkg::XP3;
    h = h ^ (h >> 32);
    return h[63:54];
  endfunction

  function automatic int alt_of(input int b, input logic [15:0] fp);
    return b ^ int'(fp_top_bits(fp));
  endfunction

  function automatic logic [15:0] lfsr_next();
    logic lsb;
    lsb = shadow_lfsr[0];
    shadow_lfsr = shadow_lfsr >> 1;
    if (lsb) shadow_lfsr = shadow_lfsr ^ 16'hB400;
    return shadow_lfsr;
  endfunction

  function automatic bit bucket_has(input int b, input logic [15:0] fp);
    for (int i = 0; i < NS; i++)
      if (shadow_slots[b][i] == fp) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit bucket_take(input int b, input logic [15:0] fp);
    for (int i = 0; i < NS; i++)
      if (shadow_slots[b][i] == fp) begin
        shadow_slots[b][i] = '0;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  function automatic bit bucket_put(input int b, input logic [15:0] fp);
    for (int i = 0; i < NS; i++)
      if (shadow_slots[b][i] == 16'd0) begin
        shadow_slots[b][i] = fp;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  function automatic logic [1:0] cuckoo_insert(input int p, input int a,
                                               input logic [15:0] fp);
    int ri;
    int slot;
    logic [15:0] carried;
    logic [15:0] bumped;
    if (bucket_has(p, fp) || bucket_has(a, fp)) return cfe_pkg::ST_NO;
    if (bucket_put(p, fp) || bucket_put(a, fp)) return cfe_pkg::ST_YES;
    carried = fp;
    ri = lfsr_next() & 1 ? p : a;
    for (int k = 0; k < cfe_pkg::MAX_KICKS; k++) begin
      slot = lfsr_next() % NS;
      bumped = shadow_slots[ri][slot];
      shadow_slots[ri][slot] = carried;
      carried = bumped;
      ri = alt_of(ri, carried);
      if (bucket_has(ri, carried)) return cfe_pkg::ST_NO;
      if (bucket_put(ri, carried)) return cfe_pkg::ST_YES;
    end
    return cfe_pkg::ST_FAIL;
  endfunction

  function automatic void wipe_filter();
    for (int b = 0; b < NB; b++)
      for (int i = 0; i < NS; i++) shadow_slots[b][i] = '0;
    shadow_count = 0;
  endfunction

  // Apply one word to the bench filter and return the expected result
  function automatic filter_result_t predict_filter(input cfe_pkg::op_t op,
                                                    input logic [63:0] key,
                                                    input logic [15:0] fp);
    filter_result_t r;
    int p;
    int a;
    p = int'(key[9:0]);
    r.status = cfe_pkg::ST_NO;
    if (op == cfe_pkg::OP_CLEAR) begin
      wipe_filter();
      r.status = cfe_pkg::ST_YES;
    end else if (fp == 16'd0) begin
      r.status = (op == cfe_pkg::OP_INSERT) ? cfe_pkg::ST_FAIL : cfe_pkg::ST_NO;
    end else begin
      a = alt_of(p, fp);
      case (op)
        cfe_pkg::OP_QUERY:
          r.status = (bucket_has(p, fp) || bucket_has(a, fp)) ? cfe_pkg::ST_YES
                                                              : cfe_pkg::ST_NO;
        cfe_pkg::OP_DELETE: begin
          if (bucket_take(p, fp) || bucket_take(a, fp)) begin
            r.status = cfe_pkg::ST_YES;
            if (shadow_count > 0) shadow_count--;
          end
        end
        default: begin
          r.status = cuckoo_insert(p, a, fp);
          if (r.status == cfe_pkg::ST_YES && shadow_count < 8191) shadow_count++;
        end
      endcase
    end
    r.count = shadow_count[12:0];
    return r;
  endfunction

  // Drive one configuration word; block must be idle
  task automatic write_seed(input logic [15:0] seed);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= seed;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_lfsr = (seed == 16'd0) ? 16'd1 : seed;
  endtask

  // Send one word after a random gap; optional typed golden result
  task automatic send_word(input stim_row_t row);
    filter_result_t exp;
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= row.op;
    s_axis_tdata <= {row.fp, row.key};
    do @(posedge clk); while (!s_axis_tready);
    exp = predict_filter(row.op, row.key, row.fp);
    if (row.has_golden) begin
      exp.status = row.golden_status;
      exp.count = row.golden_count;
    end
    pending_results.push_back(exp);
  endtask

  // Drop valid, wait until every result is back, then a settle gap
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // Sink side: random stall per word, compare field by field
  initial begin
    filter_result_t exp;
    int wait_cycles;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      wait_cycles = $urandom_range(0, 3);
      if (wait_cycles != 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected word %h", m_axis_tdata);
      end else begin
        exp = pending_results.pop_front();
        if (m_axis_tdata[1:0] !== exp.status || m_axis_tdata[14:2] !== exp.count ||
            m_axis_tdata[15] !== 1'b0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected status %0d count %0d, got status %0d count %0d",
                     exp.status, exp.count, m_axis_tdata[1:0], m_axis_tdata[14:2]);
        end
      end
    end
  end

  // Watchdog: count cycles with no accepted word on either side
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic stim_row_t mk(input cfe_pkg::op_t op, input logic [63:0] key,
                                   input logic [15:0] fp);
    stim_row_t r;
    r.op = op;
    r.key = key;
    r.fp = fp;
    r.has_golden = 1'b0;
    r.golden_status = cfe_pkg::ST_NO;
    r.golden_count = '0;
    return r;
  endfunction

  function automatic stim_row_t mk_gold(input cfe_pkg::op_t op, input logic [63:0] key,
                                        input logic [15:0] fp, input logic [1:0] st,
                                        input logic [12:0] cnt);
    stim_row_t r;
    r = mk(op, key, fp);
    r.has_golden = 1'b1;
    r.golden_status = st;
    r.golden_count = cnt;
    return r;
  endfunction

  stim_row_t directed_rows[$];
  logic [15:0] fp_pool [16];
  logic [63:0] key_pool [16];

  initial begin
    int pick;
    int roll;
    cfe_pkg::op_t op;
    stim_row_t row;
    mismatch_count = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = cfe_pkg::OP_QUERY;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    wipe_filter();
    shadow_lfsr = 16'd44257;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty filter, field extremes, zero fingerprint, duplicates, clear
    directed_rows.push_back(mk_gold(cfe_pkg::OP_QUERY, 64'd0, 16'd1,
                                    cfe_pkg::ST_NO, 13'd0));
    directed_rows.push_back(mk_gold(cfe_pkg::OP_DELETE, '1, 16'hFFFF,
                                    cfe_pkg::ST_NO, 13'd0));
    directed_rows.push_back(mk_gold(cfe_pkg::OP_INSERT, 64'd5, 16'd0,
                                    cfe_pkg::ST_FAIL, 13'd0));
    directed_rows.push_back(mk_gold(cfe_pkg::OP_QUERY, 64'd5, 16'd0,
                                    cfe_pkg::ST_NO, 13'd0));
    directed_rows.push_back(mk_gold(cfe_pkg::OP_DELETE, 64'd5, 16'd0,
                                    cfe_pkg::ST_NO, 13'd0));
    directed_rows.push_back(mk_gold(cfe_pkg::OP_INSERT, '1, 16'hFFFF,
                                    cfe_pkg::ST_YES, 13'd1));
    directed_rows.push_back(mk_gold(cfe_pkg::OP_INSERT, '1, 16'hFFFF,
                                    cfe_pkg::ST_NO, 13'd1));
    directed_rows.push_back(mk_gold(cfe_pkg::OP_QUERY, '1, 16'hFFFF,
                                    cfe_pkg::ST_YES, 13'd1));
    directed_rows.push_back(mk_gold(cfe_pkg::OP_INSERT, 64'd0, 16'd1,
                                    cfe_pkg::ST_YES, 13'd2));
    directed_rows.push_back(mk_gold(cfe_pkg::OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555,
                                    cfe_pkg::ST_YES, 13'd3));
    directed_rows.push_back(mk_gold(cfe_pkg::OP_DELETE, 64'd0, 16'd1,
                                    cfe_pkg::ST_YES, 13'd2));
    directed_rows.push_back(mk_gold(cfe_pkg::OP_QUERY, 64'd0, 16'd1,
                                    cfe_pkg::ST_NO, 13'd2));
    // Crowd one bucket so evictions happen
    for (int i = 0; i < 10; i++)
      directed_rows.push_back(mk(cfe_pkg::OP_INSERT,
                                 64'h5555_5555_5555_0007 + (64'd1024 * i),
                                 16'h0100 + 16'(i * 37)));
    directed_rows.push_back(mk_gold(cfe_pkg::OP_CLEAR, 64'd0, 16'd0,
                                    cfe_pkg::ST_YES, 13'd0));
    directed_rows.push_back(mk_gold(cfe_pkg::OP_QUERY, '1, 16'hFFFF,
                                    cfe_pkg::ST_NO, 13'd0));

    foreach (directed_rows[i]) send_word(directed_rows[i]);
    drain();
    write_seed(16'd0);

    // Random phases, one seed each, extremes among them
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: write_seed(16'hFFFF);
        2: write_seed(16'd1);
        3: write_seed(16'($urandom_range(1, 65535)));
        default: ;
      endcase
      // Small key/fingerprint pool makes hits, duplicates and crowded buckets likely
      for (int i = 0; i < 16; i++) begin
        fp_pool[i] = 16'($urandom_range(1, 65535));
        key_pool[i] = {$urandom, $urandom};
      end
      for (int n = 0; n < 100; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 50) op = cfe_pkg::OP_INSERT;
        else if (roll < 72) op = cfe_pkg::OP_QUERY;
        else if (roll < 97) op = cfe_pkg::OP_DELETE;
        else op = cfe_pkg::OP_CLEAR;
        pick = $urandom_range(0, 15);
        row = mk(op, key_pool[pick], fp_pool[pick]);
        if ($urandom_range(0, 3) == 0) begin
          // Fresh random content, half the time pinned to buckets 0 to 3 to force evictions
          row.key = {$urandom, $urandom};
          if ($urandom_range(0, 1)) row.key[9:0] = 10'($urandom_range(0, 3));
          row.fp = 16'($urandom);
        end
        if ($urandom_range(0, 49) == 0) row.fp = 16'd0;
        send_word(row);
      end
      drain();
    end

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/cfe_pkg.sv
src/cfe_ram.sv
src/cfe_hash.sv
src/cuckoo_filter_engine_unit.sv
src/cfe_checker.sv
bench/tb.sv
